// ===== rtl/ptst_pkg.sv =====
// shared types and constants for the periodic timer slot table
package ptst_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam int MAX_RESULTS   = 8;

    localparam int CMD_W    = 2;
    localparam int PERIOD_W = 16;
    localparam int IDX_W    = 8;
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 3;

    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_REG    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        SRC_FREE,
        SRC_REMOVE,
        SRC_PEND
    } t_out_src;

    typedef struct packed {
        logic     cap_en;
        logic     do_reg;
        logic     do_rem;
        logic     rd_en;
        logic     ev_wr;
        logic     ev_fire;
        logic     pend_load;
        logic     out_load;
        t_out_src out_src;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic idx_ok;
        logic ev_due;
    } t_dp_status;

endpackage

// ===== rtl/periodic_timer_slot_table_unit.sv =====
// top level of the periodic timer slot table
//
// request channel: i_valid / o_stall with i_cmd, i_period, i_slot_index.
// result channel:  o_valid / i_stall with o_kind, o_slot, o_full_res, o_last.
// a request is taken only when the controller is idle; one request is worked
// on at a time, and the next can be taken while results still sit in the
// output register.
// register and remove: the request is captured in idle, and the reply is loaded
// into the output register from the exec state once that register is free;
// the next request is taken back in idle; an out-of-range remove gives no reply.
// tick: the slot memories are walked one slot per cycle while no fire event is
// blocked at the output register (one read port, one write port), and o_stall
// stays high until the scan and the flush of the last fire event are done.
// fire events come out in ascending slot order; each is held in a pending
// register until the next fire or the scan end, so that o_last marks the last.
// when the receiver stalls, the result holds in the output register, and a
// register, a remove or the scan waits at the next result that needs to leave.
// reset clears all active bits and the output valid; periods and counters
// are written on register, so they need no clearing.
module periodic_timer_slot_table_unit #(
    parameter int NUM_SLOTS = ptst_pkg::NUM_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ptst_pkg::CMD_W-1:0]    i_cmd,
    input  logic [ptst_pkg::PERIOD_W-1:0] i_period,
    input  logic [ptst_pkg::IDX_W-1:0]    i_slot_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ptst_pkg::KIND_W-1:0]   o_kind,
    output logic [ptst_pkg::SLOT_W-1:0]   o_slot,
    output logic                          o_full_res,
    output logic                          o_last
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    ptst_pkg::t_dp_cmd    dp_cmd;
    ptst_pkg::t_dp_status dp_status;
    logic [IW-1:0]        rd_addr;

    ptst_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_cmd     (i_cmd),
        .i_status  (dp_status),
        .o_cmd_bus (dp_cmd),
        .o_rd_addr (rd_addr)
    );

    ptst_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_period     (i_period),
        .i_slot_index (i_slot_index),
        .i_rd_addr    (rd_addr),
        .i_cmd_bus    (dp_cmd),
        .o_status     (dp_status),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_slot       (o_slot),
        .o_full_res   (o_full_res),
        .o_last       (o_last)
    );

endmodule

// ===== rtl/ptst_dp.sv =====
// slot table datapath: active bits, period and counter memories, output register
module ptst_dp #(
    parameter int NUM_SLOTS = ptst_pkg::NUM_SLOTS_DEF,
    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [ptst_pkg::PERIOD_W-1:0]    i_period,
    input  logic [ptst_pkg::IDX_W-1:0]       i_slot_index,
    input  logic [IW-1:0]                    i_rd_addr,
    input  ptst_pkg::t_dp_cmd                i_cmd_bus,
    output ptst_pkg::t_dp_status             o_status,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [ptst_pkg::KIND_W-1:0]      o_kind,
    output logic [ptst_pkg::SLOT_W-1:0]      o_slot,
    output logic                             o_full_res,
    output logic                             o_last
);

    logic [NUM_SLOTS-1:0]              r_active;
    logic [ptst_pkg::PERIOD_W-1:0]     mem_period [NUM_SLOTS];
    logic [ptst_pkg::PERIOD_W-1:0]     mem_count  [NUM_SLOTS];

    logic [ptst_pkg::PERIOD_W-1:0]     r_in_period;
    logic [ptst_pkg::IDX_W-1:0]        r_in_idx;
    logic [ptst_pkg::PERIOD_W-1:0]     r_rd_period;
    logic [ptst_pkg::PERIOD_W-1:0]     r_rd_count;
    logic [IW-1:0]                     r_ev_idx;
    logic [IW-1:0]                     r_pend_slot;

    logic                              r_out_valid;
    logic [ptst_pkg::KIND_W-1:0]       r_out_kind;
    logic [ptst_pkg::SLOT_W-1:0]       r_out_slot;
    logic                              r_out_full;
    logic                              r_out_last;

    logic                              free_found;
    logic [IW-1:0]                     free_idx;
    logic [ptst_pkg::PERIOD_W-1:0]     count_inc;
    logic [IW-1:0]                     rem_idx;
    logic                              cnt_we;
    logic [IW-1:0]                     cnt_waddr;
    logic [ptst_pkg::PERIOD_W-1:0]     cnt_wdata;

    // lowest inactive slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign rem_idx   = r_in_idx[IW-1:0];
    assign count_inc = r_rd_count + 1'b1;

    assign o_status.out_free = !r_out_valid || !i_stall;
    assign o_status.idx_ok   = r_in_idx < ptst_pkg::IDX_W'(NUM_SLOTS);
    assign o_status.ev_due   = r_active[r_ev_idx] && (count_inc >= r_rd_period);

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_ev_idx;
        cnt_wdata = i_cmd_bus.ev_fire ? '0 : count_inc;
        if (i_cmd_bus.do_reg && free_found) begin
            cnt_we    = 1'b1;
            cnt_waddr = free_idx;
            cnt_wdata = '0;
        end else if (i_cmd_bus.ev_wr) begin
            cnt_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cmd_bus.do_reg && free_found) begin
            r_active[free_idx] <= 1'b1;
        end else if (i_cmd_bus.do_rem) begin
            r_active[rem_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.do_reg && free_found) begin
            mem_period[free_idx] <= r_in_period;
        end
        if (cnt_we) begin
            mem_count[cnt_waddr] <= cnt_wdata;
        end
        if (i_cmd_bus.rd_en) begin
            r_rd_period <= mem_period[i_rd_addr];
            r_rd_count  <= mem_count[i_rd_addr];
            r_ev_idx    <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.cap_en) begin
            r_in_period <= i_period;
            r_in_idx    <= i_slot_index;
        end
        if (i_cmd_bus.pend_load) begin
            r_pend_slot <= r_ev_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd_bus.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.out_load) begin
            r_out_last <= i_cmd_bus.out_last;
            case (i_cmd_bus.out_src)
                ptst_pkg::SRC_FREE: begin
                    r_out_kind <= ptst_pkg::KIND_REG;
                    r_out_slot <= free_found ? ptst_pkg::SLOT_W'(free_idx) : '0;
                    r_out_full <= !free_found;
                end
                ptst_pkg::SRC_REMOVE: begin
                    r_out_kind <= ptst_pkg::KIND_REMOVE;
                    r_out_slot <= r_in_idx[ptst_pkg::SLOT_W-1:0];
                    r_out_full <= 1'b0;
                end
                default: begin
                    r_out_kind <= ptst_pkg::KIND_FIRE;
                    r_out_slot <= ptst_pkg::SLOT_W'(r_pend_slot);
                    r_out_full <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_slot     = r_out_slot;
    assign o_full_res = r_out_full;
    assign o_last     = r_out_last;

endmodule

// ===== rtl/ptst_ctrl.sv =====
// slot table controller: command sequencing and tick scan
module ptst_ctrl #(
    parameter int NUM_SLOTS = ptst_pkg::NUM_SLOTS_DEF,
    localparam int IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int CW  = $clog2(NUM_SLOTS + 1),
    localparam int FCW = $clog2(ptst_pkg::MAX_RESULTS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ptst_pkg::CMD_W-1:0]    i_cmd,
    input  ptst_pkg::t_dp_status          i_status,
    output ptst_pkg::t_dp_cmd             o_cmd_bus,
    output logic [IW-1:0]                 o_rd_addr
);

    ptst_pkg::t_state              r_state, n_state;
    logic [ptst_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [CW-1:0]                 r_rd_idx, n_rd_idx;
    logic                          r_ev_valid, n_ev_valid;
    logic                          r_pend_valid, n_pend_valid;
    logic [FCW-1:0]                r_fire_cnt, n_fire_cnt;
    logic                          fire;
    logic                          blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptst_pkg::ST_IDLE;
            r_cmd        <= ptst_pkg::CMD_TICK;
            r_rd_idx     <= '0;
            r_ev_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_fire_cnt   <= '0;
        end else begin
            r_state      <= n_state;
            r_cmd        <= n_cmd;
            r_rd_idx     <= n_rd_idx;
            r_ev_valid   <= n_ev_valid;
            r_pend_valid <= n_pend_valid;
            r_fire_cnt   <= n_fire_cnt;
        end
    end

    assign o_stall   = r_state != ptst_pkg::ST_IDLE;
    assign o_rd_addr = r_rd_idx[IW-1:0];

    // a due slot only fires while the per-tick result budget lasts
    assign fire    = r_ev_valid && i_status.ev_due &&
                     (r_fire_cnt < FCW'(ptst_pkg::MAX_RESULTS));
    // a second fire pushes the held one out, which needs the output register
    assign blocked = fire && r_pend_valid && !i_status.out_free;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_rd_idx     = r_rd_idx;
        n_ev_valid   = r_ev_valid;
        n_pend_valid = r_pend_valid;
        n_fire_cnt   = r_fire_cnt;
        o_cmd_bus    = '0;

        unique case (r_state)
            ptst_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd_bus.cap_en = 1'b1;
                    n_cmd            = i_cmd;
                    n_state          = ptst_pkg::ST_EXEC;
                end
            end
            ptst_pkg::ST_EXEC: begin
                case (r_cmd)
                    ptst_pkg::CMD_REGISTER: begin
                        if (i_status.out_free) begin
                            o_cmd_bus.do_reg   = 1'b1;
                            o_cmd_bus.out_load = 1'b1;
                            o_cmd_bus.out_src  = ptst_pkg::SRC_FREE;
                            o_cmd_bus.out_last = 1'b1;
                            n_state            = ptst_pkg::ST_IDLE;
                        end
                    end
                    ptst_pkg::CMD_REMOVE: begin
                        if (!i_status.idx_ok) begin
                            n_state = ptst_pkg::ST_IDLE;
                        end else if (i_status.out_free) begin
                            o_cmd_bus.do_rem   = 1'b1;
                            o_cmd_bus.out_load = 1'b1;
                            o_cmd_bus.out_src  = ptst_pkg::SRC_REMOVE;
                            o_cmd_bus.out_last = 1'b1;
                            n_state            = ptst_pkg::ST_IDLE;
                        end
                    end
                    ptst_pkg::CMD_TICK: begin
                        n_rd_idx     = '0;
                        n_ev_valid   = 1'b0;
                        n_pend_valid = 1'b0;
                        n_fire_cnt   = '0;
                        n_state      = ptst_pkg::ST_SCAN;
                    end
                    default: begin
                        n_state = ptst_pkg::ST_IDLE;
                    end
                endcase
            end
            ptst_pkg::ST_SCAN: begin
                // read slot n while slot n-1 is evaluated and written back
                if (!blocked) begin
                    if (r_ev_valid) begin
                        o_cmd_bus.ev_wr = 1'b1;
                    end
                    if (fire) begin
                        o_cmd_bus.ev_fire   = 1'b1;
                        o_cmd_bus.pend_load = 1'b1;
                        n_pend_valid        = 1'b1;
                        n_fire_cnt          = r_fire_cnt + 1'b1;
                        if (r_pend_valid) begin
                            o_cmd_bus.out_load = 1'b1;
                            o_cmd_bus.out_src  = ptst_pkg::SRC_PEND;
                            o_cmd_bus.out_last = 1'b0;
                        end
                    end
                    if (r_rd_idx < CW'(NUM_SLOTS)) begin
                        o_cmd_bus.rd_en = 1'b1;
                        n_ev_valid      = 1'b1;
                        n_rd_idx        = r_rd_idx + 1'b1;
                    end else begin
                        n_ev_valid = 1'b0;
                        if (!r_ev_valid) begin
                            n_state = ptst_pkg::ST_FLUSH;
                        end
                    end
                end
            end
            ptst_pkg::ST_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = ptst_pkg::ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd_bus.out_load = 1'b1;
                    o_cmd_bus.out_src  = ptst_pkg::SRC_PEND;
                    o_cmd_bus.out_last = 1'b1;
                    n_pend_valid       = 1'b0;
                    n_state            = ptst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ptst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
